[hw/rtl/lhe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhe_pkg
// Shared types and constants for the luma histogram engine.
// ----------------------------------------------------------------------------
package lhe_pkg;

  localparam int NUM_BINS       = 256;
  localparam int BIN_IDX_W      = 8;
  localparam int OUT_W          = 32;
  localparam int COUNT_BITS_DEF = 32;
  localparam int PHASE_W        = 2;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  // Register select: byte address bit 2 (registers at 0x0 and 0x4)
  localparam logic REG_PIXEL_LAYOUT = 1'b0;
  localparam logic REG_LUMA_OFFSET  = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2
  } lhe_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_HOLD = 2'd2
  } lhe_state_e;

  typedef struct packed {
    logic               pixel_layout;
    logic [PHASE_W-1:0] luma_offset;
  } lhe_cfg_t;

endpackage

[hw/rtl/luma_histogram_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_histogram_engine_top
// 256-bin saturating luma histogram with clear, accumulate and read.
// ----------------------------------------------------------------------------
// Each input transaction clears all bins, offers one pixel byte, or reads one
// bin, and gives exactly one result transaction. Bins live in a 256-entry
// RAM with registered read; an item is handled in order (accept and issue the
// bin read, then update from the returned read data and write back), and no
// new item is accepted until it finishes, since the RAM read lies in the
// read-modify-write path. Only one item is in flight, so no forwarding
// is needed. A finished result sits in an output register, so the next item
// is accepted while it waits; if the result is still stalled when the next
// read returns, that data is held and the write back waits. Clear takes no
// sweep: a per-bin valid flag is dropped for all 256 bins at once, and a bin
// that is not valid reads as zero; reset does the same, so the block is
// ready straight after reset. In packed layout (pixel_layout = 1) only bytes
// whose row position modulo four equals luma_offset are counted; row_start
// on an accumulate puts the position back to zero. Bins stop at the largest
// COUNT_BITS value and bin_count reports them clamped to 32 bits.
// Registers: pixel_layout at 0x0, luma_offset at 0x4.
// ----------------------------------------------------------------------------
module luma_histogram_engine_top
  import lhe_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // input transactions
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            operation_i,
  input  logic                  row_start_i,
  input  logic [BIN_IDX_W-1:0]  sample_i,
  // result transactions
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_W-1:0]      bin_count_o,
  output logic                  counted_o
);

  lhe_cfg_t cfg;

  // register file, written only while idle by rule of the user; the block itself does not enforce it
  lhe_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // bin store and its read-modify-write sequencer
  lhe_bin_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .row_start_i (row_start_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bin_count_o (bin_count_o),
    .counted_o   (counted_o)
  );

endmodule

[hw/rtl/lhe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lhe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lhe_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhe_cfg_regs
// APB configuration registers: pixel layout and luma byte offset.
// ----------------------------------------------------------------------------
module lhe_cfg_regs
  import lhe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output lhe_cfg_t              cfg_o
);

  lhe_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PIXEL_LAYOUT: cfg_q.pixel_layout <= pwdata[0];
        REG_LUMA_OFFSET:  cfg_q.luma_offset  <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PIXEL_LAYOUT: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.pixel_layout};
      REG_LUMA_OFFSET:  prdata = {{(APB_DATA_W-PHASE_W){1'b0}}, cfg_q.luma_offset};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/lhe_bin_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhe_bin_core
// Bin read-modify-write sequencer around the histogram RAM.
// ----------------------------------------------------------------------------
module lhe_bin_core
  import lhe_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lhe_cfg_t             cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic                 row_start_i,
  input  logic [BIN_IDX_W-1:0] sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_W-1:0]     bin_count_o,
  output logic                 counted_o
);

  lhe_state_e state_q, state_d;

  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  cap_hold;
  logic                  ram_we;

  logic [1:0]            op_q;
  logic [BIN_IDX_W-1:0]  idx_q;
  logic                  tally_q;
  logic [PHASE_W-1:0]    row_phase_q;
  logic [PHASE_W-1:0]    phase_eff;
  logic                  tally_d;

  logic [NUM_BINS-1:0]   bin_valid_q;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] hold_q;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [COUNT_BITS-1:0] rep_src;
  logic [OUT_W-1:0]      rep_cnt;

  logic                  out_valid_q;
  logic [OUT_W-1:0]      bin_count_q;
  logic                  counted_q;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign accept   = in_valid_i & ~in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    finish     = 1'b0;
    cap_hold   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_READ: begin
        finish   = out_free;
        cap_hold = ~out_free;
      end
      ST_HOLD: finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // row phase and tally decision at accept
  assign phase_eff = row_start_i ? '0 : row_phase_q;
  assign tally_d   = ~cfg_i.pixel_layout | (phase_eff == cfg_i.luma_offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_phase_q <= '0;
    end else if (accept && operation_i == OP_ACCUM) begin
      row_phase_q <= phase_eff + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      idx_q   <= sample_i;
      tally_q <= tally_d;
    end
    if (cap_hold) begin
      hold_q <= cur_cnt;
    end
  end

  lhe_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (new_cnt),
    .re_i    (accept),
    .raddr_i (sample_i),
    .rdata_o (ram_rdata)
  );

  // unwritten-since-clear bins read as zero
  assign cur_cnt = (state_q == ST_HOLD) ? hold_q :
                   (bin_valid_q[idx_q] ? ram_rdata : '0);
  assign new_cnt = (tally_q && cur_cnt != {COUNT_BITS{1'b1}}) ?
                   cur_cnt + COUNT_BITS'(1) : cur_cnt;
  assign ram_we  = finish & (op_q == OP_ACCUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q <= '0;
    end else if (finish && op_q == OP_CLEAR) begin
      bin_valid_q <= '0;
    end else if (ram_we) begin
      bin_valid_q[idx_q] <= 1'b1;
    end
  end

  // report clamp to the output width
  assign rep_src = (op_q == OP_ACCUM) ? new_cnt : cur_cnt;
  if (COUNT_BITS > OUT_W) begin : g_clamp
    assign rep_cnt = (|rep_src[COUNT_BITS-1:OUT_W]) ? {OUT_W{1'b1}} : rep_src[OUT_W-1:0];
  end else begin : g_ext
    assign rep_cnt = OUT_W'(rep_src);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      case (op_q)
        OP_ACCUM: begin
          bin_count_q <= rep_cnt;
          counted_q   <= tally_q;
        end
        OP_READ: begin
          bin_count_q <= rep_cnt;
          counted_q   <= 1'b0;
        end
        default: begin
          bin_count_q <= '0;
          counted_q   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_count_o = bin_count_q;
  assign counted_o   = counted_q;

endmodule
